// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CSTK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define CSTK_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/cstk_pkg.sv =====
package cstk_pkg;

    localparam int COORD_BITS      = 16;
    localparam int DEF_STACK_DEPTH = 16;
    localparam int SIZE_BITS       = 15;
    localparam int DATA_W          = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int SUM_W           = COORD_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [SIZE_BITS-1:0]         size_t;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_POP_BASE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT = 2'd3;

    localparam coord_t BASE_LEFT_RST   = '0;
    localparam coord_t BASE_TOP_RST    = '0;
    localparam size_t  BASE_WIDTH_RST  = SIZE_BITS'(1024);
    localparam size_t  BASE_HEIGHT_RST = SIZE_BITS'(768);

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);

    typedef struct packed {
        coord_t bottom;
        coord_t right;
        coord_t top;
        coord_t left;
    } rect_t;

    typedef struct packed {
        logic       push;
        logic       pop_rd;
        logic       pop_base;
        logic       pop_ld;
        logic       out_ld;
        logic [1:0] status;
    } cstk_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic one;
    } cstk_sts_t;

    // inclusive far edge, start + size - 1, saturated to the coordinate range
    function automatic coord_t edge_end(input coord_t start, input size_t size);
        logic signed [SUM_W-1:0] s;
        coord_t r;
        s = SUM_W'(start) + $signed(SUM_W'(size)) - SUM_W'(1);
        if (s > SUM_MAX)
            r = COORD_BITS'(SUM_MAX);
        else if (s < SUM_MIN)
            r = COORD_BITS'(SUM_MIN);
        else
            r = COORD_BITS'(s);
        return r;
    endfunction

    function automatic rect_t make_rect(input coord_t x, input coord_t y,
                                        input size_t w, input size_t h);
        rect_t r;
        r.left   = x;
        r.top    = y;
        r.right  = edge_end(x, w);
        r.bottom = edge_end(y, h);
        return r;
    endfunction

    function automatic coord_t cmax(input coord_t a, input coord_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic coord_t cmin(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== hw/rtl/cstk_ctrl.sv =====
module cstk_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                op,
    output logic                m_tvalid,
    input  logic                m_tready,
    output cstk_pkg::cstk_cmd_t cmd,
    input  cstk_pkg::cstk_sts_t sts
);
    import cstk_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.status = ST_DONE;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_PUSH)
                    begin
                        cmd.out_ld = 1'b1;
                        if (sts.full)
                            cmd.status = ST_FULL;
                        else
                            cmd.push = 1'b1;
                    end
                    else if (sts.empty)
                    begin
                        cmd.out_ld = 1'b1;
                        cmd.status = ST_POP_BASE;
                    end
                    else if (sts.one)
                    begin
                        cmd.out_ld   = 1'b1;
                        cmd.pop_base = 1'b1;
                    end
                    else
                    begin
                        cmd.pop_rd = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.pop_ld = 1'b1;
                cmd.out_ld = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_ld)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/cstk_dp.sv =====
module cstk_dp #(
    parameter int STACK_DEPTH = cstk_pkg::DEF_STACK_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cstk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cstk_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [cstk_pkg::DATA_W-1:0]      in_data,
    input  cstk_pkg::cstk_cmd_t              cmd,
    output cstk_pkg::cstk_sts_t              sts,
    output logic [cstk_pkg::DATA_W-1:0]      out_data,
    output logic [1:0]                       out_user
);
    import cstk_pkg::*;

    localparam int LVL_W = $clog2(STACK_DEPTH);

    coord_t bl_reg;
    coord_t bt_reg;
    size_t  bw_reg;
    size_t  bh_reg;
    coord_t bl_next;
    coord_t bt_next;
    size_t  bw_next;
    size_t  bh_next;

    logic [LVL_W-1:0] level_reg;
    rect_t            cur_reg;
    rect_t            rd_reg;
    rect_t            out_reg;
    logic [1:0]       status_reg;
    rect_t            stack_mem [STACK_DEPTH];

    rect_t  base_rect;
    rect_t  in_rect;
    rect_t  push_rect;
    rect_t  new_cur;
    coord_t in_x;
    coord_t in_y;
    size_t  in_w;
    size_t  in_h;

    assign in_x = in_data[COORD_BITS-1:0];
    assign in_y = in_data[2*COORD_BITS-1:COORD_BITS];
    assign in_w = in_data[2*COORD_BITS+SIZE_BITS-1:2*COORD_BITS];
    assign in_h = in_data[2*COORD_BITS+2*SIZE_BITS-1:2*COORD_BITS+SIZE_BITS];

    always_comb
    begin
        bl_next = bl_reg;
        bt_next = bt_reg;
        bw_next = bw_reg;
        bh_next = bh_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_LEFT:   bl_next = cfg_data[COORD_BITS-1:0];
                CFG_BASE_TOP:    bt_next = cfg_data[COORD_BITS-1:0];
                CFG_BASE_WIDTH:  bw_next = cfg_data[SIZE_BITS-1:0];
                CFG_BASE_HEIGHT: bh_next = cfg_data[SIZE_BITS-1:0];
                default:         bl_next = bl_reg;
            endcase
        end
    end

    assign base_rect = make_rect(bl_next, bt_next, bw_next, bh_next);
    assign in_rect   = make_rect(in_x, in_y, in_w, in_h);

    // intersection with the current clip, empty results kept as they are
    always_comb
    begin
        push_rect.left   = cmax(cur_reg.left, in_rect.left);
        push_rect.top    = cmax(cur_reg.top, in_rect.top);
        push_rect.right  = cmin(cur_reg.right, in_rect.right);
        push_rect.bottom = cmin(cur_reg.bottom, in_rect.bottom);
    end

    always_comb
    begin
        if (cmd.push)
            new_cur = push_rect;
        else if (cmd.pop_base)
            new_cur = base_rect;
        else if (cmd.pop_ld)
            new_cur = rd_reg;
        else
            new_cur = cur_reg;
    end

    assign sts.full  = (level_reg == LVL_W'(STACK_DEPTH - 1));
    assign sts.empty = (level_reg == '0);
    assign sts.one   = (level_reg == LVL_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bl_reg    <= BASE_LEFT_RST;
            bt_reg    <= BASE_TOP_RST;
            bw_reg    <= BASE_WIDTH_RST;
            bh_reg    <= BASE_HEIGHT_RST;
            level_reg <= '0;
            cur_reg   <= make_rect(BASE_LEFT_RST, BASE_TOP_RST,
                                   BASE_WIDTH_RST, BASE_HEIGHT_RST);
        end
        else
        begin
            bl_reg <= bl_next;
            bt_reg <= bt_next;
            bw_reg <= bw_next;
            bh_reg <= bh_next;
            if (cfg_we)
            begin
                level_reg <= '0;
                cur_reg   <= base_rect;
            end
            else
            begin
                cur_reg <= new_cur;
                if (cmd.push)
                    level_reg <= level_reg + LVL_W'(1);
                else if (cmd.pop_base || cmd.pop_rd)
                    level_reg <= level_reg - LVL_W'(1);
            end
        end
    end

    // stack storage, level zero is taken from the base registers
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            stack_mem[level_reg + LVL_W'(1)] <= push_rect;
        if (cmd.pop_rd)
            rd_reg <= stack_mem[level_reg - LVL_W'(1)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_reg    <= new_cur;
            status_reg <= cmd.status;
        end
    end

    assign out_data = out_reg;
    assign out_user = status_reg;

endmodule

// ===== hw/rtl/clip_rectangle_stack.sv =====
// channel  dir  tdata (low bit up)                         tuser
// s_axis   in   rect_x, rect_y, rect_width, rect_height    operation
// m_axis   out  clip_left, clip_top, clip_right, clip_bottom  status
// cfg      in   cfg_data at register cfg_index on cfg_we    -
//
// push, refused operation and pop to level zero: handled in the idle state alone
// pop to level one or above: also the read state, for the registered stack memory read
// the result is written to the output register at the end of its transaction's last cycle
// s_tready is high only when idle and the output register is empty or its result is taken
// a result held by m_tready low stalls the input until it is taken
// reset restores the base registers and level zero; no clearing pass is needed
module clip_rectangle_stack #(
    parameter int STACK_DEPTH = cstk_pkg::DEF_STACK_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cstk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cstk_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // rect_x[15:0], rect_y[31:16], rect_width[46:32], rect_height[61:47], zero fill
    input  logic [cstk_pkg::DATA_W-1:0]     s_tdata,
    // operation[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // clip_left[15:0], clip_top[31:16], clip_right[47:32], clip_bottom[63:48]
    output logic [cstk_pkg::DATA_W-1:0]     m_tdata,
    // status[1:0]
    output logic [1:0]                      m_tuser
);
    import cstk_pkg::*;

    cstk_cmd_t cmd;
    cstk_sts_t sts;

    cstk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    cstk_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

// ===== hw/rtl/cstk_checker.sv =====
`include "assert_macros.svh"

module cstk_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [cstk_pkg::DATA_W-1:0] m_tdata,
    input logic [1:0]                  m_tuser
);
    import cstk_pkg::*;

    `CSTK_ASSERT(a_out_hold, clk, rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")
    `CSTK_NEVER(a_status_code, clk, rst_n, m_tvalid && (m_tuser != ST_DONE) && (m_tuser != ST_FULL) && (m_tuser != ST_POP_BASE), "unknown status code")
    `CSTK_NEVER(a_no_accept_stalled, clk, rst_n, m_tvalid && !m_tready && s_tready, "input taken while result stalled")
    `CSTK_ASSERT(a_result_cause, clk, rst_n, $rose(m_tvalid) |-> ($past(s_tvalid && s_tready) || $past(s_tvalid && s_tready, 2)), "result without transaction")

endmodule

bind clip_rectangle_stack cstk_checker u_cstk_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/testbench.sv =====
module testbench;
    import cstk_pkg::*;

    localparam int DEPTH  = DEF_STACK_DEPTH;
    localparam int CMAX   = (1 << (COORD_BITS - 1)) - 1;
    localparam int CMIN   = -CMAX - 1;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 200;

    typedef struct packed {
        logic   op;
        coord_t x;
        coord_t y;
        size_t  w;
        size_t  h;
    } rect_req_t;

    typedef struct packed {
        int left;
        int top;
        int right;
        int bottom;
    } box_t;

    typedef struct packed {
        logic [1:0] status;
        box_t       box;
    } clip_res_t;

    typedef struct packed {
        rect_req_t req;
        logic      chk;
        clip_res_t res;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [DATA_W-1:0]     m_tdata;
    logic [1:0]            m_tuser;

    // base rectangle registers and stack model
    coord_t    base_l;
    coord_t    base_t;
    size_t     base_w;
    size_t     base_h;
    int        lvl;
    box_t      saved_box [DEPTH];
    box_t      cur_box;

    clip_res_t clip_q [$];
    dir_row_t  rows [$];
    int        errs = 0;
    int        src_pct = 0;
    int        sink_pct = 0;
    int        push_pct [PHASES] = '{55, 75, 45, 85, 60, 70, 35, 80};
    int        src_mode [4] = '{0, 70, 0, 13};
    int        sink_mode [4] = '{0, 0, 70, 13};

    clip_rectangle_stack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("clip_rectangle_stack: mismatch");
        $finish;
    end

    function automatic int sat_coord(input longint v);
        if (v > CMAX)
            return CMAX;
        if (v < CMIN)
            return CMIN;
        return int'(v);
    endfunction

    function automatic void load_base();
        lvl = 0;
        cur_box.left   = sat_coord(longint'(base_l));
        cur_box.top    = sat_coord(longint'(base_t));
        cur_box.right  = sat_coord(longint'(base_l) + longint'(base_w) - 1);
        cur_box.bottom = sat_coord(longint'(base_t) + longint'(base_h) - 1);
        saved_box[0] = cur_box;
    endfunction

    function automatic void set_base(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_BASE_LEFT:   base_l = coord_t'(val);
            CFG_BASE_TOP:    base_t = coord_t'(val);
            CFG_BASE_WIDTH:  base_w = val[SIZE_BITS-1:0];
            CFG_BASE_HEIGHT: base_h = val[SIZE_BITS-1:0];
            default: ;
        endcase
        load_base();
    endfunction

    function automatic clip_res_t apply_clip_op(input rect_req_t q);
        clip_res_t res;
        box_t      n;
        int        far_x;
        int        far_y;
        res.status = ST_DONE;
        if (q.op == OP_PUSH) begin
            if (lvl + 1 >= DEPTH) begin
                res.status = ST_FULL;
            end
            else begin
                far_x = sat_coord(longint'(q.x) + longint'(q.w) - 1);
                far_y = sat_coord(longint'(q.y) + longint'(q.h) - 1);
                n.left   = (int'(q.x) > cur_box.left) ? int'(q.x) : cur_box.left;
                n.top    = (int'(q.y) > cur_box.top) ? int'(q.y) : cur_box.top;
                n.right  = (far_x < cur_box.right) ? far_x : cur_box.right;
                n.bottom = (far_y < cur_box.bottom) ? far_y : cur_box.bottom;
                lvl = lvl + 1;
                saved_box[lvl] = n;
                cur_box = n;
            end
        end
        else if (lvl == 0) begin
            res.status = ST_POP_BASE;
        end
        else begin
            lvl = lvl - 1;
            cur_box = saved_box[lvl];
        end
        res.box = cur_box;
        return res;
    endfunction

    function automatic rect_req_t make_req(input int pct);
        rect_req_t q;
        int        mode;
        int        span_x;
        int        span_y;
        int        xs [4];
        int        ws [4];
        xs = '{CMIN, CMAX, 0, -1};
        ws = '{0, 1, CMAX, 2};
        q.op = ($urandom_range(99) < pct) ? OP_PUSH : OP_POP;
        q.x  = coord_t'($urandom);
        q.y  = coord_t'($urandom);
        q.w  = size_t'($urandom);
        q.h  = size_t'($urandom);
        mode = $urandom_range(9);
        if (q.op == OP_PUSH && mode == 8) begin
            q.x = coord_t'(xs[$urandom_range(3)]);
            q.y = coord_t'(xs[$urandom_range(3)]);
            q.w = size_t'(ws[$urandom_range(3)]);
            q.h = size_t'(ws[$urandom_range(3)]);
        end
        else if (q.op == OP_PUSH && mode < 6) begin
            // rectangle around the current clip so nested clips often stay non-empty
            span_x = cur_box.right - cur_box.left + 1;
            span_y = cur_box.bottom - cur_box.top + 1;
            span_x = (span_x < 1) ? 1 : (span_x > CMAX) ? CMAX : span_x;
            span_y = (span_y < 1) ? 1 : (span_y > CMAX) ? CMAX : span_y;
            q.x = coord_t'(sat_coord(longint'(cur_box.left)
                  + longint'($urandom_range(0, span_x)) - span_x / 4));
            q.y = coord_t'(sat_coord(longint'(cur_box.top)
                  + longint'($urandom_range(0, span_y)) - span_y / 4));
            q.w = size_t'($urandom_range(0, span_x));
            q.h = size_t'($urandom_range(0, span_y));
        end
        return q;
    endfunction

    function automatic void tab(input logic op, input int x, input int y, input int w,
                                input int h, input logic chk, input logic [1:0] st,
                                input int l, input int t, input int r, input int b);
        dir_row_t d;
        d.req.op = op;
        d.req.x = coord_t'(x);
        d.req.y = coord_t'(y);
        d.req.w = size_t'(w);
        d.req.h = size_t'(h);
        d.chk = chk;
        d.res.status = st;
        d.res.box.left = l;
        d.res.box.top = t;
        d.res.box.right = r;
        d.res.box.bottom = b;
        rows.push_back(d);
    endfunction

    // entered and left at a falling edge
    task automatic send_item(input rect_req_t q, input logic chk, input clip_res_t typed);
        clip_res_t want;
        while ($urandom_range(99) < src_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        want = apply_clip_op(q);
        if (chk)
            want = typed;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, q.h, q.w, q.y, q.x};
        s_tuser  <= q.op;
        do
            @(posedge clk);
        while (!s_tready);
        clip_q.push_back(want);
        @(negedge clk);
    endtask

    task automatic write_base(input logic [15:0] l, input logic [15:0] t,
                              input logic [15:0] w, input logic [15:0] h);
        logic [CFG_DATA_W-1:0] vals [4];
        vals = '{l, t, w, h};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            set_base(CFG_IDX_W'(i), vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (clip_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic void cmp_field(input string nm, input int want,
                                      input logic [15:0] got);
        if (got !== 16'(want)) begin
            errs++;
            if (errs <= 10)
                $display("%s: expected %0d, got %0d", nm, want, $signed(got));
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) begin
            if (clip_q.size() == 0) begin
                errs++;
                if (errs <= 10)
                    $display("unexpected transaction: %h / %h", m_tuser, m_tdata);
            end
            else begin
                cmp_field("status", int'(clip_q[0].status), 16'(m_tuser));
                cmp_field("clip_left", clip_q[0].box.left, m_tdata[15:0]);
                cmp_field("clip_top", clip_q[0].box.top, m_tdata[31:16]);
                cmp_field("clip_right", clip_q[0].box.right, m_tdata[47:32]);
                cmp_field("clip_bottom", clip_q[0].box.bottom, m_tdata[63:48]);
                void'(clip_q.pop_front());
            end
        end
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= sink_pct);
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        base_l = BASE_LEFT_RST;
        base_t = BASE_TOP_RST;
        base_w = BASE_WIDTH_RST;
        base_h = BASE_HEIGHT_RST;
        load_base();

        tab(OP_POP, 32767, -32768, 32767, 0, 1, ST_POP_BASE, 0, 0, 1023, 767);
        tab(OP_PUSH, 0, 0, 1024, 768, 1, ST_DONE, 0, 0, 1023, 767);
        tab(OP_PUSH, -32768, -32768, 32767, 32767, 1, ST_DONE, 0, 0, -2, -2);
        tab(OP_POP, 0, 0, 0, 0, 1, ST_DONE, 0, 0, 1023, 767);
        tab(OP_PUSH, 100, 200, 0, 0, 1, ST_DONE, 100, 200, 99, 199);
        tab(OP_POP, -1, -1, 32767, 32767, 1, ST_DONE, 0, 0, 1023, 767);
        tab(OP_PUSH, 32767, 32767, 32767, 32767, 1, ST_DONE, 32767, 32767, 1023, 767);
        // empty clip stays empty as it nests
        tab(OP_PUSH, 10, 10, 5, 5, 0, ST_DONE, 0, 0, 0, 0);
        tab(OP_PUSH, -1, -1, 32767, 32767, 0, ST_DONE, 0, 0, 0, 0);
        tab(OP_PUSH, 5, 6, 7, 8, 0, ST_DONE, 0, 0, 0, 0);
        tab(OP_PUSH, -300, -200, 1, 1, 0, ST_DONE, 0, 0, 0, 0);
        tab(OP_PUSH, 0, 0, 1, 1, 0, ST_DONE, 0, 0, 0, 0);
        tab(OP_PUSH, 1023, 767, 2, 2, 0, ST_DONE, 0, 0, 0, 0);
        tab(OP_PUSH, -32768, 32767, 1, 32767, 0, ST_DONE, 0, 0, 0, 0);
        tab(OP_PUSH, 32767, -32768, 32767, 1, 0, ST_DONE, 0, 0, 0, 0);
        tab(OP_PUSH, 512, 384, 100, 100, 0, ST_DONE, 0, 0, 0, 0);
        tab(OP_PUSH, -5, -5, 10, 10, 0, ST_DONE, 0, 0, 0, 0);
        tab(OP_PUSH, 16384, 8192, 16384, 16384, 0, ST_DONE, 0, 0, 0, 0);
        tab(OP_PUSH, -16384, -8192, 300, 400, 0, ST_DONE, 0, 0, 0, 0);
        tab(OP_PUSH, 7, 9, 11, 13, 0, ST_DONE, 0, 0, 0, 0);
        // stack full
        tab(OP_PUSH, 1, 2, 3, 4, 0, ST_FULL, 0, 0, 0, 0);
        tab(OP_POP, 0, 0, 0, 0, 0, ST_DONE, 0, 0, 0, 0);
        tab(OP_POP, 0, 0, 0, 0, 0, ST_DONE, 0, 0, 0, 0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_item(rows[i].req, rows[i].chk, rows[i].res);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                drain();
                case (ph)
                    1: write_base(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
                    2: write_base(16'h7fff, 16'h7fff, 16'hffff, 16'h7fff);
                    3: write_base(16'($urandom), 16'($urandom), 16'h0000, 16'h0000);
                    4: write_base(16'h0000, 16'h0000, 16'h0001, 16'h0001);
                    5: write_base(-16'sd100, -16'sd50, 16'd640, 16'd480);
                    default: write_base(16'($urandom), 16'($urandom),
                                        16'($urandom), 16'($urandom));
                endcase
            end
            src_pct  = src_mode[ph % 4];
            sink_pct = sink_mode[ph % 4];
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(make_req(push_pct[ph]), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (clip_q.size() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (errs == 0)
            $display("clip_rectangle_stack: match");
        else
            $display("clip_rectangle_stack: mismatch");
        $finish;
    end

endmodule
